/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by weighted_running_mean_variance.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wrmv_pkg.sv */
// ----------------------------------------------------------------------------
// wrmv_pkg
// Types and constants of the weighted running mean and variance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrmv_pkg;

  localparam int VALUE_FRAC_BITS = 16;

  localparam int VALUE_W   = 32;
  localparam int WEIGHT_W  = 16;
  localparam int VAR_W     = 48;
  localparam int COUNT_W   = 32;
  localparam int WTOT_W    = 48;
  localparam int OPND_W    = 64;
  localparam int ACC_W     = OPND_W + WTOT_W;
  localparam int LEN_W     = $clog2(OPND_W) + 1;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  typedef struct packed {
    logic             start;
    op_t              op;
    logic [LEN_W-1:0] len;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  sample_value;
    logic        [WEIGHT_W-1:0] sample_weight;
  } sample_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] running_mean;
    logic        [VAR_W-1:0]   weighted_variance;
    logic        [VAR_W-1:0]   corrected_variance;
    logic        [COUNT_W-1:0] sample_count;
  } result_t;

endpackage

/* rtl/weighted_running_mean_variance.sv */
// ----------------------------------------------------------------------------
// weighted_running_mean_variance
// Weighted running mean and variance with count correction, fixed point.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time; sample_ready is high only while the
// sequencer is idle. All products and quotients go through one bit-serial
// shift/add unit that retires one bit a cycle. Per sample the sequencer runs
// multiply, divide, multiply, multiply, an accumulate step, then the variance
// divide and the count-correction divide, and loads the output register; the
// first sample skips the count-correction divide. A new sample is accepted
// only after the previous one has loaded its result. The result beat sits in an
// output register, so the next sample can be accepted while it waits; a sample
// that finishes while the register is still full holds until it drains.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_running_mean_variance #(
  parameter int VALUE_FRAC_BITS = wrmv_pkg::VALUE_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  wrmv_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_ready,
  output wrmv_pkg::result_t result
);

  localparam int VW  = wrmv_pkg::VALUE_W;
  localparam int WW  = wrmv_pkg::WEIGHT_W;
  localparam int TW  = wrmv_pkg::WTOT_W;
  localparam int CW  = wrmv_pkg::COUNT_W;
  localparam int OW  = wrmv_pkg::OPND_W;
  localparam int AW  = wrmv_pkg::ACC_W;
  localparam int VRW = wrmv_pkg::VAR_W;
  localparam int LW  = wrmv_pkg::LEN_W;
  localparam int FB  = VALUE_FRAC_BITS;
  localparam int P1W = VW + 1 + WW;

  localparam logic [LW-1:0] LEN_MUL1 = LW'(WW);
  localparam logic [LW-1:0] LEN_DIV1 = LW'(P1W);
  localparam logic [LW-1:0] LEN_MUL2 = LW'(VW);
  localparam logic [LW-1:0] LEN_MUL3 = LW'(TW);
  localparam logic [LW-1:0] LEN_DIV  = LW'(OW);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL1 = 9'b000000010,
    S_DIV1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_MUL3 = 9'b000010000,
    S_ADD  = 9'b000100000,
    S_DIV2 = 9'b001000000,
    S_DIV3 = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   go;
  logic   go_next;

  // Accumulated state
  logic signed [VW-1:0] mean_acc;
  logic [OW-1:0]        sq_dev_sum;
  logic [TW-1:0]        weight_total;
  logic [CW-1:0]        count_acc;

  // Per-sample working registers
  logic          neg;
  logic [VW-1:0] mag;
  logic [WW-1:0] wgt;
  logic [TW-1:0] w_old;
  logic [TW-1:0] w_new;
  logic [VW-1:0] rmag;
  logic [OW-1:0] prod;
  logic [OW-1:0] inc;
  logic [OW-1:0] q;
  logic [VRW-1:0] corr;

  wrmv_pkg::unit_req_t  ureq;
  wrmv_pkg::unit_stat_t ustat;
  logic [OW-1:0]        opa;
  logic [OW-1:0]        opb;
  logic [AW-1:0]        uacc;
  logic [OW-1:0]        uquo;

  logic          accept;
  logic          out_load;
  logic          in_arith;
  logic          fin_open;
  logic [VW:0]   delta;
  logic [VW:0]   delta_neg;
  logic [TW:0]   w_sum;
  logic [VW-1:0] rmag_v;
  logic [OW:0]   sq_sum;
  logic [OW:0]   corr_sum;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_load     = (state == S_FIN) && (!result_valid || result_ready);
  assign in_arith     = (state == S_MUL1) || (state == S_DIV1) || (state == S_MUL2) ||
                        (state == S_MUL3) || (state == S_DIV2) || (state == S_DIV3);
  assign fin_open     = (state == S_FIN) && !result_valid;

  always_comb begin
    delta     = {sample.sample_value[VW-1], sample.sample_value} - {mean_acc[VW-1], mean_acc};
    delta_neg = -delta;
    w_sum     = {1'b0, weight_total} + {(TW+1-WW)'(0), sample.sample_weight};
    rmag_v    = (w_new == '0) ? '0 : uquo[VW-1:0];
    sq_sum    = {1'b0, sq_dev_sum} + {1'b0, inc};
    corr_sum  = {1'b0, q} + {1'b0, uquo};
  end

  // Operand select for the shared unit; sampled only on the start cycle.
  always_comb begin
    ureq.start = go;
    ureq.op    = wrmv_pkg::OP_MUL;
    ureq.len   = LEN_MUL1;
    opa        = {(OW-VW)'(0), mag};
    opb        = {prod[WW-1:0], (OW-WW)'(0)};
    unique case (state)
      S_MUL1: begin
        opb = {wgt, (OW-WW)'(0)};
      end
      S_DIV1: begin
        ureq.op  = wrmv_pkg::OP_DIV;
        ureq.len = LEN_DIV1;
        opa      = {(OW-TW)'(0), w_new};
        opb      = {prod[P1W-1:0], (OW-P1W)'(0)};
      end
      S_MUL2: begin
        ureq.len = LEN_MUL2;
        opb      = {rmag, (OW-VW)'(0)};
      end
      S_MUL3: begin
        ureq.len = LEN_MUL3;
        opa      = prod;
        opb      = {w_old, (OW-TW)'(0)};
      end
      S_DIV2: begin
        ureq.op  = wrmv_pkg::OP_DIV;
        ureq.len = LEN_DIV;
        opa      = {(OW-TW)'(0), w_new};
        opb      = sq_dev_sum;
      end
      S_DIV3: begin
        ureq.op  = wrmv_pkg::OP_DIV;
        ureq.len = LEN_DIV;
        opa      = {(OW-CW)'(0), count_acc - CW'(1)};
        opb      = q;
      end
      S_IDLE, S_ADD, S_FIN: begin
        ureq.start = 1'b0;
      end
      default: begin
        ureq.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_MUL1;
      S_MUL1: if (ustat.done) state_next = S_DIV1;
      S_DIV1: if (ustat.done) state_next = S_MUL2;
      S_MUL2: if (ustat.done) state_next = S_MUL3;
      S_MUL3: if (ustat.done) state_next = S_ADD;
      S_ADD:  state_next = S_DIV2;
      S_DIV2: begin
        if (ustat.done) begin
          state_next = (count_acc >= CW'(2)) ? S_DIV3 : S_FIN;
        end
      end
      S_DIV3: if (ustat.done) state_next = S_FIN;
      S_FIN:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    go_next = (state_next != state) &&
              (state_next == S_MUL1 || state_next == S_DIV1 || state_next == S_MUL2 ||
               state_next == S_MUL3 || state_next == S_DIV2 || state_next == S_DIV3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      go           <= 1'b0;
      result_valid <= 1'b0;
      mean_acc     <= '0;
      sq_dev_sum   <= '0;
      weight_total <= '0;
      count_acc    <= '0;
    end else begin
      state <= state_next;
      go    <= go_next;

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (accept) begin
        if (count_acc != '1) begin
          count_acc <= count_acc + CW'(1);
        end
      end

      if (state == S_DIV1 && ustat.done) begin
        // Step the mean toward the sample by the truncated magnitude.
        mean_acc <= neg ? mean_acc - rmag_v : mean_acc + rmag_v;
      end

      if (state == S_ADD) begin
        sq_dev_sum   <= sq_sum[OW] ? '1 : sq_sum[OW-1:0];
        weight_total <= w_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      neg   <= delta[VW];
      mag   <= delta[VW] ? delta_neg[VW-1:0] : delta[VW-1:0];
      wgt   <= sample.sample_weight;
      w_old <= weight_total;
      w_new <= w_sum[TW] ? '1 : w_sum[TW-1:0];
    end
    if (state == S_MUL1 && ustat.done) begin
      prod <= uacc[OW-1:0];
    end
    if (state == S_DIV1 && ustat.done) begin
      rmag <= rmag_v;
    end
    if (state == S_MUL2 && ustat.done) begin
      prod <= uacc[OW-1:0];
    end
    if (state == S_MUL3 && ustat.done) begin
      // Drop the value fraction bits; saturate if the increment spills past 64 bits.
      inc <= (|uacc[AW-1:OW+FB]) ? '1 : uacc[OW+FB-1:FB];
    end
    if (state == S_DIV2 && ustat.done) begin
      q    <= (w_new == '0) ? '0 : uquo;
      corr <= '0;
    end
    if (state == S_DIV3 && ustat.done) begin
      corr <= (|corr_sum[OW:VRW]) ? '1 : corr_sum[VRW-1:0];
    end
    if (out_load) begin
      result.running_mean       <= mean_acc;
      result.weighted_variance  <= (|q[OW-1:VRW]) ? '1 : q[VRW-1:0];
      result.corrected_variance <= corr;
      result.sample_count       <= count_acc;
    end
  end

  wrmv_shift_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (ureq),
    .opa  (opa),
    .opb  (opb),
    .stat (ustat),
    .acc  (uacc),
    .quo  (uquo)
  );

  `ASSERT_IMPL(a_accept_unit_idle, accept, !ustat.busy && !ustat.done, "beat taken, unit busy")
  `ASSERT_IMPL(a_done_in_arith, ustat.done, in_arith, "unit finished outside an arithmetic step")
  `ASSERT_NEXT(a_fin_loads, fin_open, result_valid && sample_ready, "result not loaded")
  `ASSERT_IMPL(a_count_nonzero, result_valid, result.sample_count != '0, "zero count in result")

endmodule

/* rtl/wrmv_shift_unit.sv */
// ----------------------------------------------------------------------------
// wrmv_shift_unit
// Bit-serial multiply and restoring divide sharing one adder, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrmv_shift_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  wrmv_pkg::unit_req_t            req,
  input  logic [wrmv_pkg::OPND_W-1:0]    opa,
  input  logic [wrmv_pkg::OPND_W-1:0]    opb,
  output wrmv_pkg::unit_stat_t           stat,
  output logic [wrmv_pkg::ACC_W-1:0]     acc,
  output logic [wrmv_pkg::OPND_W-1:0]    quo
);

  localparam int OW = wrmv_pkg::OPND_W;
  localparam int AW = wrmv_pkg::ACC_W;

  logic [OW-1:0]              a_r;
  wrmv_pkg::op_t              op_r;
  logic [OW-1:0]              sh;
  logic [wrmv_pkg::LEN_W-1:0] cnt;
  logic                       busy;
  logic                       done;

  logic [AW-1:0] x;
  logic [AW-1:0] y;
  logic [AW-1:0] sum;
  logic          is_div;
  logic          ge;

  // Multiply: acc = 2*acc + (bit ? a : 0). Divide: trial subtract of a.
  always_comb begin
    is_div = (op_r == wrmv_pkg::OP_DIV);
    x      = {acc[AW-2:0], is_div & sh[OW-1]};
    if (is_div) begin
      y = ~{(AW-OW)'(0), a_r};
    end else if (sh[OW-1]) begin
      y = {(AW-OW)'(0), a_r};
    end else begin
      y = '0;
    end
    sum = x + y + AW'(is_div);
    ge  = ~sum[AW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == wrmv_pkg::LEN_W'(1));
      if (busy) begin
        cnt <= cnt - wrmv_pkg::LEN_W'(1);
        if (cnt == wrmv_pkg::LEN_W'(1)) begin
          busy <= 1'b0;
        end
        if (is_div) begin
          acc <= ge ? sum : x;
          sh  <= {sh[OW-2:0], ge};
        end else begin
          acc <= sum;
          sh  <= {sh[OW-2:0], 1'b0};
        end
      end else if (req.start) begin
        a_r  <= opa;
        op_r <= req.op;
        sh   <= opb;
        acc  <= '0;
        cnt  <= req.len;
        busy <= 1'b1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = sh;

endmodule

/* tb/tb_weighted_running_mean_variance.sv */
// ----------------------------------------------------------------------------
// tb_weighted_running_mean_variance
// Self-checking bench for the weighted running mean and variance block.
// ----------------------------------------------------------------------------
// Each accepted sample beat feeds an in-bench model of the weighted update,
// and the model's result is queued. Result beats are compared field by field
// against the oldest queued result. Stimulus is a directed startup sequence,
// a back-pressure burst and a long random mix, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_weighted_running_mean_variance;

  localparam logic [63:0] MAX48         = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX64         = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          RANDOM_ITEMS  = 1650;
  localparam int          DRAIN_CYCLES  = 400;
  localparam int          CYCLE_LIMIT   = 4_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  wrmv_pkg::sample_t sample = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  wrmv_pkg::result_t result;

  // running statistics as the block should hold them
  logic signed [63:0] stat_mean = '0;
  logic        [63:0] stat_dev_sq = '0;
  logic        [63:0] stat_weight_total = '0;
  logic        [31:0] stat_count = '0;

  wrmv_pkg::result_t pending_results[$];
  int      mismatch_count = 0;
  int      samples_sent = 0;
  int      results_checked = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;
  bit      hold_request = 1'b0;
  int      hold_left = 0;

  weighted_running_mean_variance u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Apply one sample to the tracked statistics and return the expected result.
  function automatic wrmv_pkg::result_t advance_stats(input wrmv_pkg::sample_t s);
    logic signed [63:0] x;
    logic signed [63:0] delta;
    logic        [63:0] w, w_old, w_new, mag, step, prod, inc, q, extra, corr;
    logic       [127:0] full;
    logic        [64:0] sum;
    wrmv_pkg::result_t  r;
    x     = {{32{s.sample_value[31]}}, s.sample_value};
    w     = {48'd0, s.sample_weight};
    w_old = stat_weight_total;
    w_new = w_old + w;
    if (stat_count != '1) stat_count = stat_count + 32'd1;
    if (w_new > MAX48) w_new = MAX48;

    // step magnitude truncates, sign follows the deviation
    delta = x - stat_mean;
    mag   = delta[63] ? 64'd0 - delta : delta;
    step  = (w_new != 64'd0) ? (mag * w) / w_new : 64'd0;
    stat_mean = delta[63] ? stat_mean - step : stat_mean + step;

    prod = mag * step;
    full = {64'd0, w_old} * {64'd0, prod};
    inc  = (full[127:80] != '0) ? MAX64 : full[79:16];
    sum  = {1'b0, stat_dev_sq} + {1'b0, inc};
    stat_dev_sq = sum[64] ? MAX64 : sum[63:0];
    stat_weight_total = w_new;

    q = (stat_weight_total != 64'd0) ? stat_dev_sq / stat_weight_total : 64'd0;
    if (stat_count >= 32'd2) begin
      extra = q / ({32'd0, stat_count} - 64'd1);
      corr  = (extra > MAX48 || q > MAX48 - extra) ? MAX48 : q + extra;
    end else begin
      corr = 64'd0;
    end

    r.running_mean       = stat_mean[31:0];
    r.weighted_variance  = (q > MAX48) ? MAX48[47:0] : q[47:0];
    r.corrected_variance = corr[47:0];
    r.sample_count       = stat_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input wrmv_pkg::result_t got);
    wrmv_pkg::result_t exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
      mismatch_count++;
    end else begin
      exp_r = pending_results.pop_front();
      check_field("running_mean", 64'(exp_r.running_mean), 64'(got.running_mean));
      check_field("weighted_variance", 64'(exp_r.weighted_variance),
                  64'(got.weighted_variance));
      check_field("corrected_variance", 64'(exp_r.corrected_variance),
                  64'(got.corrected_variance));
      check_field("sample_count", 64'(exp_r.sample_count), 64'(got.sample_count));
      results_checked++;
    end
  endtask

  // Result side: check accepted beats, then pick ready for the next edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) check_result(result);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !(idle_on && $urandom_range(99) < 14);
      end
    end
  end

  task automatic send_sample(input logic [31:0] value, input logic [15:0] weight);
    wrmv_pkg::sample_t s;
    bit                taken;
    s.sample_value  = value;
    s.sample_weight = weight;
    if (idle_on && $urandom_range(99) < 14) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 300)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do begin
      @(posedge clk);
      taken = sample_valid && sample_ready;
    end while (!taken);
    pending_results.push_back(advance_stats(s));
    samples_sent++;
  endtask

  // Hold the sender off until every queued result has come back.
  task automatic wait_results_drained();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2, 3: v = stat_mean[31:0] + 32'($urandom_range(8191)) - 32'd4096;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_weight();
    logic [15:0] w;
    case ($urandom_range(11))
      0:       w = 16'h0000;
      1:       w = 16'hFFFF;
      2, 3, 4: w = 16'($urandom_range(1, 255));
      default: w = 16'($urandom_range(65535));
    endcase
    return w;
  endfunction

  // The first beats see an empty weight total and a count below two.
  task automatic test_startup_and_extremes();
    send_sample(32'h7FFF_FFFF, 16'h0000);
    send_sample(32'h8000_0000, 16'h0000);
    send_sample(32'h8000_0000, 16'h0001);
    send_sample(32'h7FFF_FFFF, 16'hFFFF);
    send_sample(32'h0000_0000, 16'h0000);
    send_sample(32'hFFFF_FFFF, 16'h0001);
    send_sample(32'h0001_0000, 16'h0100);
    send_sample(32'hFFFF_0000, 16'h0100);
    // swing between the rails at full weight to drive the deviation sum to its cap
    repeat (4) begin
      send_sample(32'h8000_0000, 16'hFFFF);
      send_sample(32'h7FFF_FFFF, 16'hFFFF);
    end
    send_sample(32'h0000_0001, 16'h0080);
    send_sample(32'h5555_5555, 16'hAAAA);
    send_sample(32'hAAAA_AAAA, 16'h5555);
    send_sample(32'h0000_0000, 16'hFFFF);
    wait_results_drained();
  endtask

  // Stall the result side long enough that the input backs up.
  task automatic test_result_backpressure();
    hold_request = 1'b1;
    repeat (12) send_sample(pick_value(), pick_weight());
    wait_results_drained();
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = !(i >= 600 && i < 900);
      send_sample(pick_value(), pick_weight());
    end
    idle_on = 1'b1;
    wait_results_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_startup_and_extremes();
    test_result_backpressure();
    test_random_stream();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               pending_results.size());
      mismatch_count++;
    end
    $display("Sent %0d samples (rail swings, zero weights, long output stall) and",
             samples_sent);
    $display("checked %0d result beats, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
